FILE: rtl/core/deq_pkg.sv
package deq_pkg;

    // Default sizing of the queue storage
    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the transaction fields
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 11;

    // Requested operation
    typedef enum logic [1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_BACK   = 2'd2,
        KIND_POP_FRONT  = 2'd3
    } t_deq_kind;

    // Result status; code 3 is never produced
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_deq_status;

    typedef struct packed {
        t_deq_kind                 kind;
        logic signed [WORD_W-1:0]  value;
    } t_deq_in;

    typedef struct packed {
        logic signed [WORD_W-1:0]  popped_value;
        t_deq_status               status;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
        logic signed [WORD_W-1:0]  front_value;
        logic signed [WORD_W-1:0]  back_value;
    } t_deq_out;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // input transaction taken this cycle
        logic finish_now;   // result written at the accept edge
        logic finish_load;  // result written once the end-word read returns
    } t_deq_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_read;    // current request pops and leaves one or more words
    } t_deq_stat;

endpackage

FILE: rtl/core/double_ended_queue_core.sv
// Bounded double-ended queue of DATA_WIDTH-bit words in a DEPTH-entry ring.
// Each input transaction pushes or pops at either end and returns exactly one
// result: the popped word, a status (pop on empty and push on full are
// flagged and leave the queue unchanged), and the count, empty flag and
// front/back words after the operation. Pushes, failed operations and pops
// that empty the queue finish at the accept edge, so the result is valid the
// next cycle and a new transaction can be taken every cycle while results
// are taken. A pop that leaves one or more words fetches the new end word
// through the single registered read port of the ring and finishes once it
// returns, taking no new transaction until then. The output register lets the
// next transaction be accepted in the same cycle a waiting result is taken.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_deq_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_deq_out o_out_data
);

    t_deq_cmd  cmd;
    t_deq_stat stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

FILE: rtl/core/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    input  t_deq_stat i_stat,
    output t_deq_cmd  o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // Handshake and command decode
    always_comb begin
        slot_free         = !r_out_valid || i_out_ready;
        o_in_ready        = (r_state == S_IDLE) && slot_free;
        o_cmd.accept      = i_in_valid && o_in_ready;
        o_cmd.finish_now  = o_cmd.accept && !i_stat.need_read;
        o_cmd.finish_load = (r_state == S_LOAD) && slot_free;

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_stat.need_read) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.finish_now || o_cmd.finish_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and output-valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/deq_datapath.sv
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_deq_cmd  i_cmd,
    output t_deq_stat o_stat,
    input  t_deq_in   i_in_data,
    output t_deq_out  o_out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [PTR_W-1:0]      t_ptr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_word;

    // Ring storage, one write and one registered read per cycle
    t_word r_mem [DEPTH];
    t_word r_rd_data;

    // Control state
    t_ptr  r_front_ptr, n_front_ptr;
    t_ptr  r_back_ptr,  n_back_ptr;
    t_cnt  r_count,     n_count;

    // Cached end words and the result register
    t_word    r_front_w, n_front_w;
    t_word    r_back_w,  n_back_w;
    logic [WORD_W-1:0] r_pend_popped, n_pend_popped;
    logic     r_pend_back, n_pend_back;
    t_deq_out r_out, n_out;

    logic  wr_en;
    t_ptr  wr_addr;
    t_word wr_data;
    logic  rd_en;
    t_ptr  rd_addr;

    logic        is_empty_now;
    logic        is_full_now;
    logic [WORD_W-1:0] popped;
    t_deq_status status;

    function automatic t_ptr ptr_next(input t_ptr p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic t_ptr ptr_prev(input t_ptr p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

    // 32-bit field into a stored word: sign extend or truncate
    function automatic t_word to_store(input logic [WORD_W-1:0] v);
        logic [63:0] e;
        e = {{(64 - WORD_W){v[WORD_W-1]}}, v};
        return e[DATA_WIDTH-1:0];
    endfunction

    // Stored word back to a 32-bit field, sign extended from DATA_WIDTH
    function automatic logic [WORD_W-1:0] from_store(input t_word w);
        logic [63:0] e;
        e = 64'($signed(w));
        return e[WORD_W-1:0];
    endfunction

    function automatic t_deq_out make_out(
        input logic [WORD_W-1:0] pop_v,
        input t_deq_status       st,
        input t_cnt              cnt,
        input t_word             fw,
        input t_word             bw
    );
        t_deq_out    o;
        logic [31:0] c;
        c              = 32'(cnt);
        o.popped_value = pop_v;
        o.status       = st;
        o.count        = c[COUNT_W-1:0];
        o.is_empty     = (cnt == '0);
        o.front_value  = o.is_empty ? '0 : from_store(fw);
        o.back_value   = o.is_empty ? '0 : from_store(bw);
        return o;
    endfunction

    // Next-state logic for pointers, count, end words and result
    always_comb begin
        is_empty_now = (r_count == '0);
        is_full_now  = (r_count == CNT_W'(DEPTH));
        o_stat.need_read = ((i_in_data.kind == KIND_POP_BACK)
                            || (i_in_data.kind == KIND_POP_FRONT))
                           && (r_count > CNT_W'(1));

        n_front_ptr   = r_front_ptr;
        n_back_ptr    = r_back_ptr;
        n_count       = r_count;
        n_front_w     = r_front_w;
        n_back_w      = r_back_w;
        n_pend_popped = r_pend_popped;
        n_pend_back   = r_pend_back;
        n_out         = r_out;
        wr_en         = 1'b0;
        wr_addr       = r_back_ptr;
        wr_data       = to_store(i_in_data.value);
        rd_en         = 1'b0;
        rd_addr       = ptr_next(r_front_ptr);
        popped        = '0;
        status        = ST_OK;

        if (i_cmd.accept) begin
            unique case (i_in_data.kind)
                KIND_PUSH_BACK: begin
                    if (is_full_now) begin
                        status = ST_PUSH_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = r_back_ptr;
                        n_back_ptr = ptr_next(r_back_ptr);
                        n_count    = r_count + CNT_W'(1);
                        n_back_w   = wr_data;
                        if (is_empty_now) begin
                            n_front_w = wr_data;
                        end
                    end
                end
                KIND_PUSH_FRONT: begin
                    if (is_full_now) begin
                        status = ST_PUSH_FULL;
                    end else begin
                        n_front_ptr = ptr_prev(r_front_ptr);
                        wr_en       = 1'b1;
                        wr_addr     = n_front_ptr;
                        n_count     = r_count + CNT_W'(1);
                        n_front_w   = wr_data;
                        if (is_empty_now) begin
                            n_back_w = wr_data;
                        end
                    end
                end
                KIND_POP_BACK: begin
                    if (is_empty_now) begin
                        status = ST_POP_EMPTY;
                    end else begin
                        n_back_ptr = ptr_prev(r_back_ptr);
                        n_count    = r_count - CNT_W'(1);
                        popped     = from_store(r_back_w);
                        // new back word sits just below the new back pointer
                        rd_en       = o_stat.need_read;
                        rd_addr     = ptr_prev(n_back_ptr);
                        n_pend_back = 1'b1;
                    end
                end
                KIND_POP_FRONT: begin
                    if (is_empty_now) begin
                        status = ST_POP_EMPTY;
                    end else begin
                        n_front_ptr = ptr_next(r_front_ptr);
                        n_count     = r_count - CNT_W'(1);
                        popped      = from_store(r_front_w);
                        rd_en       = o_stat.need_read;
                        rd_addr     = n_front_ptr;
                        n_pend_back = 1'b0;
                    end
                end
                default: status = ST_OK;
            endcase
            n_pend_popped = popped;
        end

        // Result straight from the updated state
        if (i_cmd.finish_now) begin
            n_out = make_out(popped, status, n_count, n_front_w, n_back_w);
        end

        // Result once the new end word is back from the ring
        if (i_cmd.finish_load) begin
            if (r_pend_back) begin
                n_back_w = r_rd_data;
            end else begin
                n_front_w = r_rd_data;
            end
            n_out = make_out(r_pend_popped, ST_OK, r_count, n_front_w, n_back_w);
        end
    end

    // Ring storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_ptr <= '0;
            r_back_ptr  <= '0;
            r_count     <= '0;
        end else begin
            r_front_ptr <= n_front_ptr;
            r_back_ptr  <= n_back_ptr;
            r_count     <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_front_w     <= n_front_w;
        r_back_w      <= n_back_w;
        r_pend_popped <= n_pend_popped;
        r_pend_back   <= n_pend_back;
        r_out         <= n_out;
    end

    assign o_out_data = r_out;

endmodule

FILE: rtl/core/deq_checker.sv
module deq_checker
    import deq_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_deq_out o_out_data
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // No input transaction is taken while a result waits
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !(i_in_valid && o_in_ready))
        else $error("input transaction taken while a result was stalled");

    // Empty queue reports zero end words
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_empty
            |-> (o_out_data.front_value == '0) && (o_out_data.back_value == '0))
        else $error("end words not zero on empty queue");

    // A flagged transaction returns no popped word
    a_err_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK)
            |-> (o_out_data.popped_value == '0))
        else $error("flagged transaction returned a popped word");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
